>>> src/ppmfb_pkg.sv
// Package for the PPM frame pulse builder.
// Holds the item and configuration types, register indexes and frame constants.
// Depends on nothing.
`timescale 1ns / 1ps

package ppmfb_pkg;

   // Field widths of the channels.
   localparam int VALUE_W    = 16;
   localparam int CENTER_W   = 13;
   localparam int DUR_W      = 15;
   localparam int RANGE_W    = 11;
   localparam int MARKER_W   = 12;
   localparam int ADJUST_W   = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 12;

   // Frame remainder arithmetic width.
   localparam int REM_W = 20;

   // Up to four result items leave for one channel beat.
   localparam int MAX_ITEMS = 4;
   localparam int SLOT_W    = 2;
   localparam int COUNT_W   = 3;

   localparam int DEFAULT_MAX_CHANNELS = 32;

   // Frame timing constants, in half-microsecond ticks.
   localparam logic signed [REM_W-1:0] BASE_FRAME_TICKS = 20'sd45000;
   localparam logic signed [REM_W-1:0] ADJUST_STEP      = 20'sd1000;
   localparam logic signed [REM_W-1:0] SYNC_MAX         = 20'sd32767;
   localparam logic signed [REM_W-1:0] SYNC_MIN         = 20'sd9000;
   localparam logic signed [REM_W-1:0] SETUP_TICKS_S    = 20'sd1000;
   localparam logic [DUR_W-1:0]        SETUP_TICKS      = 15'd1000;

   // Register reset values.
   localparam logic [RANGE_W-1:0]  RANGE_RESET    = 11'd1024;
   localparam logic [MARKER_W-1:0] MARKER_RESET   = 12'd600;
   localparam logic                POLARITY_RESET = 1'b0;
   localparam logic [ADJUST_W-1:0] ADJUST_RESET   = 8'd0;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PULSE_RANGE    = 4'd0,
      CSR_MARKER_TICKS   = 4'd1,
      CSR_PULSE_POLARITY = 4'd2,
      CSR_FRAME_ADJUST   = 4'd3
   } csr_index_type;

   // Current configuration as seen by the item logic.
   typedef struct packed {
      logic [RANGE_W-1:0]         pulse_range;
      logic [MARKER_W-1:0]        marker_ticks;
      logic                       pulse_polarity;
      logic signed [ADJUST_W-1:0] frame_length_adjust;
   } cfg_type;

   // One channel beat.
   typedef struct packed {
      logic signed [VALUE_W-1:0] channel_value;
      logic [CENTER_W-1:0]       center_ticks;
      logic                      last_channel;
   } chan_type;

   // One two-phase pulse item.
   typedef struct packed {
      logic [DUR_W-1:0] first_duration;
      logic             first_level;
      logic [DUR_W-1:0] second_duration;
      logic             second_level;
      logic             frame_end;
   } item_type;

endpackage

>>> src/ppmfb_if.sv
// Channel interfaces of the PPM frame pulse builder: channel beats,
// pulse items and configuration writes. Depends on ppmfb_pkg.
`timescale 1ns / 1ps

interface ppmfb_req_if;
   import ppmfb_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] channel_value;
   logic [CENTER_W-1:0]       center_ticks;
   logic                      last_channel;

   modport source (output valid, output channel_value, output center_ticks,
                   output last_channel, input ready);
   modport sink   (input valid, input channel_value, input center_ticks,
                   input last_channel, output ready);
endinterface

interface ppmfb_rsp_if;
   import ppmfb_pkg::*;
   logic             valid;
   logic             ready;
   logic [DUR_W-1:0] first_duration;
   logic             first_level;
   logic [DUR_W-1:0] second_duration;
   logic             second_level;
   logic             frame_end;

   modport source (output valid, output first_duration, output first_level,
                   output second_duration, output second_level,
                   output frame_end, input ready);
   modport sink   (input valid, input first_duration, input first_level,
                   input second_duration, input second_level,
                   input frame_end, output ready);
endinterface

interface ppmfb_csr_if;
   import ppmfb_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/ppm_frame_pulse_builder.sv
// Top level of the PPM frame pulse builder: input register, item logic,
// item buffer and configuration registers. Depends on ppmfb_pkg, ppmfb_if
// and ppmfb_item_calc.
`timescale 1ns / 1ps

// A channel beat is taken into an input register and, once the item buffer
// is free, turned by a single pass of logic into its pulse items, which fill a
// four-slot item buffer that hands out one item per cycle while the receiver
// is ready. An ordinary channel gives one item, so channels stream at one per
// cycle unless the receiver stalls; the last channel of a frame gives its channel
// item plus sync, setup and terminator items and holds the item buffer until all
// of them have left. A channel past MAX_CHANNELS gives no channel item. The
// frame length adjust takes effect at the start of the next frame. The
// configuration port is always ready; write it only while the block is idle.
module ppm_frame_pulse_builder #(
   parameter int MAX_CHANNELS = ppmfb_pkg::DEFAULT_MAX_CHANNELS
) (
   input logic         clock,
   input logic         reset,
   ppmfb_req_if.sink   req_bus,
   ppmfb_rsp_if.source rsp_bus,
   ppmfb_csr_if.sink   csr_bus
);
   import ppmfb_pkg::*;

   localparam int TAKEN_W = $clog2(MAX_CHANNELS + 1);

   cfg_type                 cfg_ff, cfg_in;
   logic                    in_valid_ff, in_valid_in;
   chan_type                chan_ff;
   logic [TAKEN_W-1:0]      taken_ff, taken_in;
   logic signed [REM_W-1:0] rem_ff, rem_in;
   item_type                slot_ff [MAX_ITEMS];
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic [SLOT_W-1:0]       ptr_ff, ptr_in;

   item_type                calc_items [MAX_ITEMS];
   logic [COUNT_W-1:0]      calc_count;
   logic [TAKEN_W-1:0]      calc_taken;
   logic signed [REM_W-1:0] calc_rem;

   logic                    req_fire;
   logic                    rsp_fire;
   logic                    buf_free;
   logic                    load;
   item_type                head;

   // Handshakes.
   assign rsp_fire = rsp_bus.valid & rsp_bus.ready;
   assign req_fire = req_bus.valid & req_bus.ready;
   assign buf_free = (count_ff == '0) || ((count_ff == COUNT_W'(1)) && rsp_fire);
   assign load     = in_valid_ff & buf_free;
   assign req_bus.ready = ~in_valid_ff | load;
   assign csr_bus.ready = 1'b1;

   // Item logic on the registered channel beat.
   ppmfb_item_calc #(
      .MAX_CHANNELS (MAX_CHANNELS),
      .TAKEN_W      (TAKEN_W)
   ) u_calc (
      .cfg            (cfg_ff),
      .chan           (chan_ff),
      .taken          (taken_ff),
      .remainder      (rem_ff),
      .items          (calc_items),
      .item_count     (calc_count),
      .taken_next     (calc_taken),
      .remainder_next (calc_rem)
   );

   // Configuration register decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_PULSE_RANGE:    cfg_in.pulse_range    = csr_bus.data[RANGE_W-1:0];
            CSR_MARKER_TICKS:   cfg_in.marker_ticks   = csr_bus.data[MARKER_W-1:0];
            CSR_PULSE_POLARITY: cfg_in.pulse_polarity = csr_bus.data[0];
            CSR_FRAME_ADJUST:   cfg_in.frame_length_adjust =
                                   signed'(csr_bus.data[ADJUST_W-1:0]);
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   // Next state of the input register, frame state and item buffer.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end

      taken_in = taken_ff;
      rem_in   = rem_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      if (load) begin
         taken_in = calc_taken;
         rem_in   = calc_rem;
         count_in = calc_count;
         ptr_in   = '0;
      end else if (rsp_fire) begin
         count_in = count_ff - COUNT_W'(1);
         ptr_in   = ptr_ff + SLOT_W'(1);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_range         <= RANGE_RESET;
         cfg_ff.marker_ticks        <= MARKER_RESET;
         cfg_ff.pulse_polarity      <= POLARITY_RESET;
         cfg_ff.frame_length_adjust <= signed'(ADJUST_RESET);
         in_valid_ff <= 1'b0;
         taken_ff    <= '0;
         rem_ff      <= BASE_FRAME_TICKS;
         count_ff    <= '0;
         ptr_ff      <= '0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
         taken_ff    <= taken_in;
         rem_ff      <= rem_in;
         count_ff    <= count_in;
         ptr_ff      <= ptr_in;
      end
   end

   // Payload registers: the channel beat and the item slots.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         chan_ff.channel_value <= req_bus.channel_value;
         chan_ff.center_ticks  <= req_bus.center_ticks;
         chan_ff.last_channel  <= req_bus.last_channel;
      end
      if (load) begin
         for (int i = 0; i < MAX_ITEMS; i++) begin
            slot_ff[i] <= calc_items[i];
         end
      end
   end

   // Result beat from the head slot.
   assign head                    = slot_ff[ptr_ff];
   assign rsp_bus.valid           = (count_ff != '0);
   assign rsp_bus.first_duration  = head.first_duration;
   assign rsp_bus.first_level     = head.first_level;
   assign rsp_bus.second_duration = head.second_duration;
   assign rsp_bus.second_level    = head.second_level;
   assign rsp_bus.frame_end       = head.frame_end;

endmodule

>>> src/ppmfb_item_calc.sv
// Item logic of the PPM frame pulse builder: turns one channel beat and the
// frame state into up to four pulse items and the next frame state.
// Depends on ppmfb_pkg.
`timescale 1ns / 1ps

module ppmfb_item_calc #(
   parameter int MAX_CHANNELS = ppmfb_pkg::DEFAULT_MAX_CHANNELS,
   parameter int TAKEN_W      = $clog2(MAX_CHANNELS + 1)
) (
   input  ppmfb_pkg::cfg_type                  cfg,
   input  ppmfb_pkg::chan_type                 chan,
   input  logic [TAKEN_W-1:0]                  taken,
   input  logic signed [ppmfb_pkg::REM_W-1:0]  remainder,
   output ppmfb_pkg::item_type                 items [ppmfb_pkg::MAX_ITEMS],
   output logic [ppmfb_pkg::COUNT_W-1:0]       item_count,
   output logic [TAKEN_W-1:0]                  taken_next,
   output logic signed [ppmfb_pkg::REM_W-1:0]  remainder_next
);
   import ppmfb_pkg::*;

   localparam int CALC_W = VALUE_W + 1;
   localparam logic [TAKEN_W-1:0] TAKEN_MAX = TAKEN_W'(MAX_CHANNELS);

   logic                      mark_lv;
   logic                      idle_lv;
   logic signed [CALC_W-1:0]  val_ext;
   logic signed [CALC_W-1:0]  range_pos;
   logic signed [CALC_W-1:0]  range_neg;
   logic signed [CALC_W-1:0]  clamped;
   logic signed [CALC_W-1:0]  width;
   logic signed [CALC_W-1:0]  rest_w;
   logic [DUR_W-1:0]          rest_dur;
   logic signed [REM_W-1:0]   adjust_ext;
   logic signed [REM_W-1:0]   frame_base;
   logic signed [REM_W-1:0]   rem_cur;
   logic signed [REM_W-1:0]   rem_new;
   logic signed [REM_W-1:0]   sync_rem;
   logic signed [REM_W-1:0]   sync_clamped;
   logic signed [REM_W-1:0]   sync_dur;
   logic                      take_chan;
   item_type                  chan_item;
   item_type                  sync_item;
   item_type                  setup_item;
   item_type                  term_item;

   assign mark_lv = cfg.pulse_polarity;
   assign idle_lv = ~cfg.pulse_polarity;

   // Clamp the channel value to the configured range and add its center.
   always_comb begin
      val_ext   = CALC_W'(chan.channel_value);
      range_pos = signed'({{(CALC_W - RANGE_W){1'b0}}, cfg.pulse_range});
      range_neg = -range_pos;
      clamped   = val_ext;
      if (clamped > range_pos) begin
         clamped = range_pos;
      end
      if (clamped < range_neg) begin
         clamped = range_neg;
      end
      width  = clamped + signed'({{(CALC_W - CENTER_W){1'b0}}, chan.center_ticks});
      rest_w = width - signed'({{(CALC_W - MARKER_W){1'b0}}, cfg.marker_ticks});
      rest_dur = (rest_w < 0) ? '0 : rest_w[DUR_W-1:0];
   end

   // Frame remainder: reload at frame start, subtract each taken channel.
   always_comb begin
      adjust_ext = {{(REM_W - ADJUST_W){cfg.frame_length_adjust[ADJUST_W-1]}},
                    cfg.frame_length_adjust};
      frame_base = BASE_FRAME_TICKS + adjust_ext * ADJUST_STEP;
      take_chan  = (taken < TAKEN_MAX);
      rem_cur    = (taken == '0) ? frame_base : remainder;
      rem_new    = rem_cur - {{(REM_W - CALC_W){width[CALC_W-1]}}, width};
      sync_rem   = take_chan ? rem_new : rem_cur;
      sync_clamped = sync_rem;
      if (sync_clamped > SYNC_MAX) begin
         sync_clamped = SYNC_MAX;
      end
      if (sync_clamped < SYNC_MIN) begin
         sync_clamped = SYNC_MIN;
      end
      sync_dur = sync_clamped - SETUP_TICKS_S;
   end

   // The four kinds of item.
   always_comb begin
      chan_item.first_duration  = DUR_W'(cfg.marker_ticks);
      chan_item.first_level     = mark_lv;
      chan_item.second_duration = rest_dur;
      chan_item.second_level    = idle_lv;
      chan_item.frame_end       = 1'b0;

      sync_item.first_duration  = DUR_W'(cfg.marker_ticks);
      sync_item.first_level     = mark_lv;
      sync_item.second_duration = sync_dur[DUR_W-1:0];
      sync_item.second_level    = idle_lv;
      sync_item.frame_end       = 1'b0;

      setup_item.first_duration  = SETUP_TICKS;
      setup_item.first_level     = idle_lv;
      setup_item.second_duration = '0;
      setup_item.second_level    = idle_lv;
      setup_item.frame_end       = 1'b0;

      term_item           = '0;
      term_item.frame_end = 1'b1;
   end

   // Pack the items in output order and work out the next frame state.
   always_comb begin
      if (take_chan) begin
         items[0] = chan_item;
         items[1] = sync_item;
         items[2] = setup_item;
         items[3] = term_item;
         item_count = chan.last_channel ? COUNT_W'(4) : COUNT_W'(1);
         taken_next = taken + TAKEN_W'(1);
         remainder_next = rem_new;
      end else begin
         items[0] = sync_item;
         items[1] = setup_item;
         items[2] = term_item;
         items[3] = term_item;
         item_count = chan.last_channel ? COUNT_W'(3) : COUNT_W'(0);
         taken_next = taken;
         remainder_next = rem_cur;
      end
      if (chan.last_channel) begin
         taken_next = '0;
      end
   end

endmodule

>>> tb/sv/ppm_frame_pulse_builder_tb.sv
// Self-checking testbench for the PPM frame pulse builder.
// Drives channel beats and register writes, predicts every pulse item and
// compares it with the block's output. Depends on ppmfb_pkg and ppmfb_if.
`timescale 1ns / 1ps

module ppm_frame_pulse_builder_tb;
   import ppmfb_pkg::*;

   localparam int CHAN_CAPACITY = DEFAULT_MAX_CHANNELS;
   localparam int RANDOM_BEATS  = 155;
   localparam int PHASE_BEATS   = 30;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_GAP       = 10;
   localparam int LONG_HOLD     = 120;
   localparam int QUIET_LIMIT   = 1000;
   localparam int MAX_REPORTS   = 40;

   // First register index past the implemented ones; writes there are dropped.
   localparam logic [CSR_IDX_W-1:0] FIRST_UNUSED_INDEX =
      CSR_IDX_W'(int'(CSR_FRAME_ADJUST) + 1);
   localparam int LAST_INDEX = (1 << CSR_IDX_W) - 1;

   typedef enum logic {ROW_BEAT, ROW_REG} row_kind_type;
   typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_PATTERN, STALL_HEAVY}
      stall_mode_type;

   // One line of the directed plan: a register write or a channel beat,
   // optionally with its pulse items typed in by hand.
   typedef struct {
      row_kind_type          kind;
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [CSR_DATA_W-1:0] reg_data;
      chan_type              beat;
      int                    typed_count;
      item_type              typed[MAX_ITEMS];
   } plan_row_type;

   logic clock;
   logic reset;

   ppmfb_req_if req_bus ();
   ppmfb_rsp_if rsp_bus ();
   ppmfb_csr_if csr_bus ();

   ppm_frame_pulse_builder #(.MAX_CHANNELS(CHAN_CAPACITY)) uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Shadow copy of the block's registers and frame state.
   cfg_type model_cfg;
   int      frame_ticks_left;
   int      chans_in_frame;

   item_type expected_pulses[$];

   int  mismatch_count = 0;
   int  beats_sent     = 0;
   int  beats_dropped  = 0;
   int  frames_closed  = 0;
   int  pulses_checked = 0;
   int  reg_writes     = 0;
   int  long_holds     = 0;
   int  burst_left     = 0;
   bit  hold_request   = 1'b0;

   initial clock = 1'b0;
   always begin
      #2 clock = ~clock;
   end

   function automatic item_type make_pulse(input int d0, input bit l0, input int d1,
                                           input bit l1, input bit fe);
      item_type p;
      p.first_duration  = DUR_W'(d0);
      p.first_level     = l0;
      p.second_duration = DUR_W'(d1);
      p.second_level    = l1;
      p.frame_end       = fe;
      return p;
   endfunction

   function automatic plan_row_type beat_row(input int value, input int center, input bit last,
                                             input int n_typed = 0,
                                             input item_type t0 = '0, t1 = '0, t2 = '0,
                                             t3 = '0);
      plan_row_type row;
      row.kind                = ROW_BEAT;
      row.reg_index           = '0;
      row.reg_data            = '0;
      row.beat.channel_value  = VALUE_W'(value);
      row.beat.center_ticks   = CENTER_W'(center);
      row.beat.last_channel   = last;
      row.typed_count         = n_typed;
      row.typed[0]            = t0;
      row.typed[1]            = t1;
      row.typed[2]            = t2;
      row.typed[3]            = t3;
      return row;
   endfunction

   function automatic plan_row_type reg_row(input logic [CSR_IDX_W-1:0] index,
                                            input logic [CSR_DATA_W-1:0] data);
      plan_row_type row;
      row             = beat_row(0, 0, 1'b0);
      row.kind        = ROW_REG;
      row.reg_index   = index;
      row.reg_data    = data;
      return row;
   endfunction

   function automatic int frame_base_ticks();
      return 45000 + int'($signed(model_cfg.frame_length_adjust)) * 1000;
   endfunction

   // Works out the pulse items that one channel beat causes and advances the
   // shadow frame state.
   function automatic int predict_pulses(input chan_type beat, output item_type pulses[MAX_ITEMS]);
      int n;
      int width;
      int rest;
      int bound;
      bit mark_lv;
      bit idle_lv;
      n       = 0;
      mark_lv = model_cfg.pulse_polarity;
      idle_lv = ~mark_lv;
      bound   = int'(model_cfg.pulse_range);
      foreach (pulses[i]) pulses[i] = '0;

      // A frame picks up the frame length adjust when its first channel comes.
      if (chans_in_frame == 0) frame_ticks_left = frame_base_ticks();

      // Channels past capacity give no channel item and leave the remainder alone.
      if (chans_in_frame < CHAN_CAPACITY) begin
         width = int'($signed(beat.channel_value));
         if (width > bound) width = bound;
         if (width < -bound) width = -bound;
         width += int'(beat.center_ticks);
         frame_ticks_left -= width;
         width -= int'(model_cfg.marker_ticks);
         if (width < 0) width = 0;
         pulses[n] = make_pulse(model_cfg.marker_ticks, mark_lv, width, idle_lv, 1'b0);
         n++;
         chans_in_frame++;
      end else begin
         beats_dropped++;
      end

      // Closing a frame adds the sync gap, the setup item and the terminator.
      if (beat.last_channel) begin
         rest = frame_ticks_left;
         if (rest > 32767) rest = 32767;
         if (rest < 9000) rest = 9000;
         pulses[n]     = make_pulse(model_cfg.marker_ticks, mark_lv, rest - 1000, idle_lv, 1'b0);
         pulses[n + 1] = make_pulse(1000, idle_lv, 0, idle_lv, 1'b0);
         pulses[n + 2] = make_pulse(0, 1'b0, 0, 1'b0, 1'b1);
         n += 3;
         chans_in_frame   = 0;
         frame_ticks_left = frame_base_ticks();
         frames_closed++;
      end
      return n;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t ns: pulse item %0d, %s: got %0d, expected %0d",
                  $time, pulses_checked, what, got, want);
   endtask

   // Called at a falling edge; returns at a falling edge with valid still high.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      case (index)
         CSR_PULSE_RANGE:    model_cfg.pulse_range         = data[RANGE_W-1:0];
         CSR_MARKER_TICKS:   model_cfg.marker_ticks        = data[MARKER_W-1:0];
         CSR_PULSE_POLARITY: model_cfg.pulse_polarity      = data[0];
         CSR_FRAME_ADJUST:   model_cfg.frame_length_adjust = data[ADJUST_W-1:0];
         default: ;
      endcase
      reg_writes++;
      @(negedge clock);
   endtask

   // Offers one channel beat and queues its pulse items once it is taken.
   // Gaps between bursts are inserted here, after the beat.
   task automatic send_beat(input plan_row_type row);
      item_type predicted[MAX_ITEMS];
      int n;
      req_bus.valid         <= 1'b1;
      req_bus.channel_value <= row.beat.channel_value;
      req_bus.center_ticks  <= row.beat.center_ticks;
      req_bus.last_channel  <= row.beat.last_channel;
      do @(posedge clock); while (!req_bus.ready);
      n = predict_pulses(row.beat, predicted);
      if (row.typed_count > 0) begin
         for (int i = 0; i < row.typed_count; i++) expected_pulses.push_back(row.typed[i]);
      end else begin
         for (int i = 0; i < n; i++) expected_pulses.push_back(predicted[i]);
      end
      beats_sent++;
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, MAX_GAP)) @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
      end
   endtask

   // Lets every expected item come out, then a few more cycles in case a
   // beat without any item is still in flight.
   task automatic wait_drained();
      while (expected_pulses.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Compare each accepted pulse item with the oldest expectation.
   always @(posedge clock) begin : pulse_checker
      item_type got;
      item_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.first_duration  = rsp_bus.first_duration;
         got.first_level     = rsp_bus.first_level;
         got.second_duration = rsp_bus.second_duration;
         got.second_level    = rsp_bus.second_level;
         got.frame_end       = rsp_bus.frame_end;
         if (expected_pulses.size() == 0) begin
            report_mismatch("item with nothing expected, first_duration",
                            got.first_duration, -1);
         end else begin
            want = expected_pulses.pop_front();
            if (got.first_duration !== want.first_duration)
               report_mismatch("first_duration", got.first_duration, want.first_duration);
            if (got.first_level !== want.first_level)
               report_mismatch("first_level", got.first_level, want.first_level);
            if (got.second_duration !== want.second_duration)
               report_mismatch("second_duration", got.second_duration, want.second_duration);
            if (got.second_level !== want.second_level)
               report_mismatch("second_level", got.second_level, want.second_level);
            if (got.frame_end !== want.frame_end)
               report_mismatch("frame_end", got.frame_end, want.frame_end);
         end
         pulses_checked++;
      end
   end

   // Receiver back-pressure: a changing stall mode, plus an occasional long
   // hold-off that lets the block fill up.
   initial begin : receiver
      int             hold_left;
      int             mode_left;
      stall_mode_type mode;
      logic [7:0]     pattern;
      hold_left = 0;
      mode_left = 0;
      mode      = STALL_NONE;
      pattern   = 8'h01;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
            long_holds++;
         end
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(20, 80);
            pattern   = 8'($urandom) | 8'h01;
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            case (mode)
               STALL_NONE:    rsp_bus.ready <= 1'b1;
               STALL_COIN:    rsp_bus.ready <= 1'($urandom_range(0, 1));
               STALL_PATTERN: begin
                  rsp_bus.ready <= pattern[0];
                  pattern = {pattern[0], pattern[7:1]};
               end
               default:       rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Ends the run when no beat moves on any channel for too long.
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Timeout: no beat accepted for %0d cycles, %0d items still expected.",
               QUIET_LIMIT, expected_pulses.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      plan_row_type          directed_plan[$];
      logic [CSR_DATA_W-1:0] reg_data;
      int                    phase;
      int                    phase_beats;
      int                    random_beats;
      int                    frame_len;
      int                    bound;
      int                    value;
      int                    center;

      // Every input known from the start, with reset asserted.
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.channel_value = '0;
      req_bus.center_ticks  = '0;
      req_bus.last_channel  = 1'b0;
      rsp_bus.ready         = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = '0;
      csr_bus.data          = '0;
      model_cfg.pulse_range         = RANGE_RESET;
      model_cfg.marker_ticks        = MARKER_RESET;
      model_cfg.pulse_polarity      = POLARITY_RESET;
      model_cfg.frame_length_adjust = ADJUST_RESET;
      chans_in_frame   = 0;
      frame_ticks_left = frame_base_ticks();
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed part: reset settings, field extremes, saturation, the sync
      // clamp at both ends, polarity, adjust taking effect at frame start and
      // a write to an unused index.
      directed_plan = '{
         beat_row(0, 3000, 1'b0, 1, make_pulse(600, 0, 2400, 1, 0)),
         beat_row(32767, 3000, 1'b0, 1, make_pulse(600, 0, 3424, 1, 0)),
         beat_row(-32768, 0, 1'b0, 1, make_pulse(600, 0, 0, 1, 0)),
         beat_row(-1, 8191, 1'b1),
         beat_row(0, 0, 1'b1, 4, make_pulse(600, 0, 0, 1, 0),
                  make_pulse(600, 0, 31767, 1, 0), make_pulse(1000, 1, 0, 1, 0),
                  make_pulse(0, 0, 0, 0, 1)),
         reg_row(CSR_FRAME_ADJUST, 12'h07F),
         beat_row(32767, 8191, 1'b1),
         reg_row(CSR_FRAME_ADJUST, 12'h080),
         beat_row(0, 100, 1'b1, 4, make_pulse(600, 0, 0, 1, 0),
                  make_pulse(600, 0, 8000, 1, 0), make_pulse(1000, 1, 0, 1, 0),
                  make_pulse(0, 0, 0, 0, 1)),
         reg_row(CSR_PULSE_RANGE, 12'h000),
         reg_row(CSR_MARKER_TICKS, 12'hFFF),
         reg_row(CSR_PULSE_POLARITY, 12'h001),
         beat_row(-32768, 8191, 1'b0, 1, make_pulse(4095, 1, 4096, 0, 0)),
         beat_row(32767, 0, 1'b1, 4, make_pulse(4095, 1, 0, 0, 0),
                  make_pulse(4095, 1, 8000, 0, 0), make_pulse(1000, 0, 0, 0, 0),
                  make_pulse(0, 0, 0, 0, 1)),
         reg_row(CSR_PULSE_RANGE, 12'h7FF),
         reg_row(CSR_MARKER_TICKS, 12'h000),
         reg_row(CSR_PULSE_POLARITY, 12'h000),
         reg_row(CSR_FRAME_ADJUST, 12'h000),
         reg_row(FIRST_UNUSED_INDEX, 12'hFFF),
         beat_row(32767, 8191, 1'b0, 1, make_pulse(0, 0, 10238, 1, 0)),
         beat_row(-32768, 8191, 1'b1),
         beat_row(12345, 1234, 1'b1)
      };

      foreach (directed_plan[i]) begin
         if (directed_plan[i].kind == ROW_REG) begin
            // A write from the row before must not be taken again while draining.
            req_bus.valid <= 1'b0;
            csr_bus.valid <= 1'b0;
            wait_drained();
            write_reg(directed_plan[i].reg_index, directed_plan[i].reg_data);
         end else begin
            csr_bus.valid <= 1'b0;
            send_beat(directed_plan[i]);
         end
      end

      // Random part: phases of whole frames, each under fresh settings. The
      // first phase opens with a frame past capacity; one phase starts with a
      // long receiver hold-off while the sender keeps offering beats.
      phase        = 0;
      random_beats = 0;
      while (random_beats < RANDOM_BEATS) begin
         req_bus.valid <= 1'b0;
         wait_drained();

         case ($urandom_range(0, 3))
            0:       reg_data = 12'd0;
            1:       reg_data = 12'd2047;
            2:       reg_data = 12'd1024;
            default: reg_data = CSR_DATA_W'($urandom_range(0, 2047));
         endcase
         write_reg(CSR_PULSE_RANGE, reg_data);
         case ($urandom_range(0, 3))
            0:       reg_data = 12'd0;
            1:       reg_data = 12'd4095;
            2:       reg_data = 12'd600;
            default: reg_data = CSR_DATA_W'($urandom_range(0, 4095));
         endcase
         write_reg(CSR_MARKER_TICKS, reg_data);
         write_reg(CSR_PULSE_POLARITY, CSR_DATA_W'($urandom));
         case ($urandom_range(0, 3))
            0:       reg_data = 12'h080;
            1:       reg_data = 12'h07F;
            2:       reg_data = 12'h000;
            default: reg_data = CSR_DATA_W'($urandom_range(0, 255));
         endcase
         reg_data[CSR_DATA_W-1:ADJUST_W] = 4'($urandom);
         write_reg(CSR_FRAME_ADJUST, reg_data);
         write_reg(CSR_IDX_W'($urandom_range(FIRST_UNUSED_INDEX, LAST_INDEX)),
                   CSR_DATA_W'($urandom));
         csr_bus.valid <= 1'b0;

         if (phase == 2) begin
            hold_request = 1'b1;
            burst_left   = 40;
         end

         phase_beats = 0;
         while (phase_beats < PHASE_BEATS && random_beats < RANDOM_BEATS) begin
            if (phase == 0 && phase_beats == 0)
               frame_len = CHAN_CAPACITY + 4;
            else if ($urandom_range(0, 9) == 0)
               frame_len = $urandom_range(CHAN_CAPACITY - 2, CHAN_CAPACITY + 6);
            else
               frame_len = $urandom_range(1, 8);
            for (int k = 0; k < frame_len; k++) begin
               bound = int'(model_cfg.pulse_range);
               case ($urandom_range(0, 3))
                  0:       value = int'($urandom_range(0, 65535)) - 32768;
                  1:       value = int'($urandom_range(0, 2 * bound + 128)) - bound - 64;
                  2:       value = $urandom_range(0, 1) ? bound : -bound;
                  default: value = int'($urandom_range(0, 600)) - 300;
               endcase
               center = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                     : $urandom_range(2000, 4000);
               send_beat(beat_row(value, center, k == frame_len - 1));
               phase_beats++;
               random_beats++;
            end
         end
         phase++;
      end

      req_bus.valid <= 1'b0;
      wait_drained();

      $display("Covered %0d channel beats (%0d past capacity) in %0d closed frames, %0d writes.",
               beats_sent, beats_dropped, frames_closed, reg_writes);
      $display("Checked %0d pulse items over %0d random phases with %0d long hold-off(s).",
               pulses_checked, phase, long_holds);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches found.", mismatch_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
